[rtl/core/mfr_pkg.sv]
// mfr_pkg: shared types and constants of the meter frame receiver.
// Used by meter_frame_receiver in rtl/core (mfr_ram does not use it); depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mfr_pkg;

    localparam int unsigned MAX_FRAME_DEF = 256;
    localparam int unsigned MIN_FRAME_LEN = 20;
    localparam int unsigned LEN_OFFSET    = 13;
    localparam int unsigned LEN_POS       = 10;
    localparam int unsigned LEN_W         = 9;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned IDLE_W        = 16;
    localparam int unsigned CFG_DATA_W    = 16;
    localparam int unsigned CFG_INDEX_W   = 2;

    localparam logic [IDLE_W-1:0] IDLE_MAX          = '1;
    localparam logic [BYTE_W-1:0] START_BYTE_RESET  = 8'd104;
    localparam logic [BYTE_W-1:0] TAIL_BYTE_RESET   = 8'd22;
    localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RESET = 16'd50;

    typedef enum logic [2:0] {
        KIND_BYTE  = 3'd0,
        KIND_TICK  = 3'd1,
        KIND_CHECK = 3'd2,
        KIND_REARM = 3'd3,
        KIND_READ  = 3'd4
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_BYTE   = 2'd0,
        CFG_TAIL_BYTE    = 2'd1,
        CFG_IDLE_TIMEOUT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [BYTE_W-1:0] rx_byte;
        logic [BYTE_W-1:0] read_index;
    } in_req_t;

    typedef struct packed {
        logic              frame_ready;
        logic [LEN_W-1:0]  frame_length;
        logic [BYTE_W-1:0] read_data;
    } out_req_t;

endpackage

`default_nettype wire

[rtl/core/mfr_ram.sv]
// mfr_ram: generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module mfr_ram #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH  = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/meter_frame_receiver.sv]
// meter_frame_receiver: start/length/tail frame assembler with idle timeout.
// Depends on mfr_pkg and mfr_ram.
//
// Takes one request per clock while in_stall is low and gives one result per
// request (state update and buffer access on acceptance, then the registered buffer
// read resolved into the output register). Throughput is one request per cycle
// unless stalled, bounded by the single write and single read port of the frame
// buffer, which are never needed in the same cycle. Two result slots let a new
// request in while a finished result waits on out_stall. No clearing pass after
// reset: buffer entries are only read below the current byte count.
`timescale 1ns / 1ps
`default_nettype none

module meter_frame_receiver #(
    parameter int unsigned MAX_FRAME = mfr_pkg::MAX_FRAME_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [mfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [mfr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire mfr_pkg::in_req_t                   in_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output mfr_pkg::out_req_t                       out_data
);

    localparam int unsigned AW = $clog2(MAX_FRAME);
    localparam int unsigned CW = $clog2(MAX_FRAME + 1);
    localparam int unsigned LW = (CW > mfr_pkg::LEN_W) ? CW : mfr_pkg::LEN_W;
    localparam int unsigned HW = (CW > mfr_pkg::BYTE_W) ? CW : mfr_pkg::BYTE_W;

    // configuration
    logic [mfr_pkg::BYTE_W-1:0] start_byte_reg;
    logic [mfr_pkg::BYTE_W-1:0] tail_byte_reg;
    logic [mfr_pkg::IDLE_W-1:0] idle_timeout_reg;

    // frame state
    logic [CW-1:0]              byte_count_reg, byte_count_next;
    logic                       ready_flag_reg, ready_flag_next;
    logic [mfr_pkg::IDLE_W-1:0] idle_ticks_reg, idle_ticks_next;
    logic [mfr_pkg::BYTE_W-1:0] first_byte_reg, first_byte_next;
    logic [mfr_pkg::BYTE_W-1:0] length_byte_reg, length_byte_next;

    // result pipeline
    logic                       a_valid_reg, a_valid_next;
    logic                       a_ready_reg;
    logic [mfr_pkg::LEN_W-1:0]  a_len_reg;
    logic                       a_hit_reg;
    logic                       b_valid_reg, b_valid_next;
    mfr_pkg::out_req_t          b_data_reg;

    logic                       in_accept;
    logic                       b_load;
    logic                       timed_out;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic                       rd_en;
    logic                       rd_hit;
    logic [mfr_pkg::BYTE_W-1:0] rd_data;

    assign b_load    = a_valid_reg && (!b_valid_reg || !out_stall);
    assign in_stall  = a_valid_reg && b_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign timed_out = idle_ticks_reg > idle_timeout_reg;

    assign a_valid_next = in_accept || (a_valid_reg && !b_load);
    assign b_valid_next = b_load || (b_valid_reg && out_stall);

    assign rd_hit = HW'(in_data.read_index) < HW'(byte_count_reg);
    assign rd_en  = in_accept && (in_data.kind == mfr_pkg::KIND_READ);

    always_comb
    begin
        logic [CW-1:0] base;
        logic [CW-1:0] count_inc;
        logic [LW-1:0] len_sum;

        byte_count_next  = byte_count_reg;
        ready_flag_next  = ready_flag_reg;
        idle_ticks_next  = idle_ticks_reg;
        first_byte_next  = first_byte_reg;
        length_byte_next = length_byte_reg;
        wr_en            = 1'b0;
        len_sum          = '0;
        base             = byte_count_reg;
        if (timed_out || (first_byte_reg != start_byte_reg)
            || (byte_count_reg >= CW'(MAX_FRAME)))
        begin
            base = '0;
        end
        wr_addr   = AW'(base);
        count_inc = base + CW'(1);

        if (in_accept)
        begin
            case (in_data.kind)
                mfr_pkg::KIND_BYTE:
                begin
                    if (!ready_flag_reg)
                    begin
                        wr_en           = 1'b1;
                        idle_ticks_next = '0;
                        byte_count_next = count_inc;
                        if (base == '0)
                        begin
                            first_byte_next = in_data.rx_byte;
                        end
                        if (base == CW'(mfr_pkg::LEN_POS))
                        begin
                            length_byte_next = in_data.rx_byte;
                        end
                        len_sum = LW'(length_byte_next) + LW'(mfr_pkg::LEN_OFFSET);
                        if ((count_inc >= CW'(mfr_pkg::MIN_FRAME_LEN))
                            && (len_sum == LW'(count_inc))
                            && (in_data.rx_byte == tail_byte_reg))
                        begin
                            ready_flag_next = 1'b1;
                        end
                    end
                end
                mfr_pkg::KIND_TICK:
                begin
                    if (idle_ticks_reg != mfr_pkg::IDLE_MAX)
                    begin
                        idle_ticks_next = idle_ticks_reg + 16'd1;
                    end
                end
                mfr_pkg::KIND_CHECK:
                begin
                    if (timed_out && (byte_count_reg != '0))
                    begin
                        ready_flag_next = 1'b1;
                    end
                end
                mfr_pkg::KIND_REARM:
                begin
                    byte_count_next  = '0;
                    ready_flag_next  = 1'b0;
                    first_byte_next  = '0;
                    length_byte_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg   <= mfr_pkg::START_BYTE_RESET;
            tail_byte_reg    <= mfr_pkg::TAIL_BYTE_RESET;
            idle_timeout_reg <= mfr_pkg::IDLE_TIMEOUT_RESET;
            byte_count_reg   <= '0;
            ready_flag_reg   <= 1'b0;
            idle_ticks_reg   <= mfr_pkg::IDLE_MAX;
            first_byte_reg   <= '0;
            length_byte_reg  <= '0;
            a_valid_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    mfr_pkg::CFG_START_BYTE:   start_byte_reg   <= cfg_data[7:0];
                    mfr_pkg::CFG_TAIL_BYTE:    tail_byte_reg    <= cfg_data[7:0];
                    mfr_pkg::CFG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            byte_count_reg  <= byte_count_next;
            ready_flag_reg  <= ready_flag_next;
            idle_ticks_reg  <= idle_ticks_next;
            first_byte_reg  <= first_byte_next;
            length_byte_reg <= length_byte_next;
            a_valid_reg     <= a_valid_next;
            b_valid_reg     <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_ready_reg <= ready_flag_next;
            a_len_reg   <= mfr_pkg::LEN_W'(byte_count_next);
            a_hit_reg   <= rd_hit && (in_data.kind == mfr_pkg::KIND_READ);
        end
        if (b_load)
        begin
            b_data_reg.frame_ready  <= a_ready_reg;
            b_data_reg.frame_length <= a_len_reg;
            b_data_reg.read_data    <= a_hit_reg ? rd_data : '0;
        end
    end

    mfr_ram #(
        .DATA_W (mfr_pkg::BYTE_W),
        .DEPTH  (MAX_FRAME)
    ) u_frame_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_data.rx_byte),
        .rd_en   (rd_en),
        .rd_addr (AW'(in_data.read_index)),
        .rd_data (rd_data)
    );

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CW'(MAX_FRAME))
        else $error("byte count beyond buffer size");

    a_locked_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_data.kind == mfr_pkg::KIND_BYTE) && ready_flag_reg)
        |=> ($stable(byte_count_reg) && $stable(idle_ticks_reg) && ready_flag_reg))
        else $error("byte taken while frame locked");

    a_byte_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_data.kind == mfr_pkg::KIND_BYTE) && !ready_flag_reg)
        |=> (idle_ticks_reg == '0) && (byte_count_reg != '0))
        else $error("stored byte did not restart idle time");

    a_ready_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ready_flag_reg) |-> $past(in_accept
            && ((in_data.kind == mfr_pkg::KIND_BYTE)
                || (in_data.kind == mfr_pkg::KIND_CHECK))))
        else $error("frame ready set without byte or check");

endmodule

`default_nettype wire
